// ===== hw/rtl/vtsi_pkg.sv =====
package vtsi_pkg;

    localparam int unsigned MAX_RESULTS = 5;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int unsigned POS_W       = 5;
    localparam int unsigned HELD_DEPTH  = 4;

    localparam logic CMD_STRIP  = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    localparam logic [POS_W-1:0] POS_FIRST    = 5'd0;
    localparam logic [POS_W-1:0] POS_SA_END   = 5'd11;
    localparam logic [POS_W-1:0] POS_TYPE_HI  = 5'd12;
    localparam logic [POS_W-1:0] POS_TYPE_LO  = 5'd13;
    localparam logic [POS_W-1:0] POS_TCI_HI   = 5'd14;
    localparam logic [POS_W-1:0] POS_TCI_LO   = 5'd15;
    localparam logic [POS_W-1:0] POS_INNER_HI = 5'd16;
    localparam logic [POS_W-1:0] POS_INNER_LO = 5'd17;
    localparam logic [POS_W-1:0] POS_MAX      = 5'd31;

    localparam logic [7:0] TPID_HI = 8'h81;
    localparam logic [7:0] TPID_LO = 8'h00;

endpackage

// ===== hw/rtl/vlan_tag_strip_insert.sv =====
// 802.1Q tag strip / insert on a byte-wide frame stream.
// Input channel: i_in_valid / o_in_ready with i_cmd, i_data_byte, i_last_byte,
// i_tag_vid and i_tag_pcp. Command and tag are taken from the frame's first byte.
// Output channel: o_out_valid / i_out_ready with the rewritten byte, its last flag
// and, on the last byte only, the strip status (tag_removed, VID, inner EtherType).
// Strip mode drops bytes 12-15 of a frame of 16 bytes or more tagged 0x8100;
// insert mode adds 0x81 0x00 and the TCI after byte 11 of a frame of 12 or more.
// A result word goes into the pending buffer when its input word is taken, then
// into the output register. Throughput is one word per cycle while the receiver
// does not stall; a byte that yields k words (up to five: the inserted tag, or a
// held run of bytes 11-14 being released) holds o_in_ready low while the pending
// buffer drains into the output register. In strip mode, bytes 11-13 (and byte 14
// of a tagged frame) are held and give no output until the tag decision is made.
// Reset clears the frame position, frame state, pending count and output valid.
// When the receiver stalls, the output register holds its word and the pending
// buffer stops; a new input word is taken only once the buffer will be empty.
module vlan_tag_strip_insert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [11:0] i_tag_vid,
    input  logic [2:0]  i_tag_pcp,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic        o_tag_removed,
    output logic [11:0] o_removed_vid,
    output logic [15:0] o_inner_ethertype
);

    logic [vtsi_pkg::POS_W-1:0] r_pos, n_pos;
    logic                       r_mode, n_mode;
    logic [15:0]                r_tci, n_tci;
    logic                       r_seen, n_seen;
    logic                       r_found, n_found;
    logic [11:0]                r_vid, n_vid;
    logic [15:0]                r_inner, n_inner;
    logic [7:0]                 r_held [vtsi_pkg::HELD_DEPTH];
    logic [7:0]                 n_held [vtsi_pkg::HELD_DEPTH];

    logic [7:0]                 r_pb [vtsi_pkg::MAX_RESULTS];
    logic [7:0]                 n_pb [vtsi_pkg::MAX_RESULTS];
    logic [vtsi_pkg::CNT_W-1:0] r_prem, n_cnt;
    logic                       r_plast;
    logic                       r_pfound;
    logic [11:0]                r_pvid;
    logic [15:0]                r_pinner;

    logic                       r_out_valid;
    logic [7:0]                 r_out_byte;
    logic                       r_out_last;
    logic                       r_out_removed;
    logic [11:0]                r_out_vid;
    logic [15:0]                r_out_inner;

    logic w_in_acc;
    logic w_out_load;
    logic w_first;
    logic w_final;
    logic [vtsi_pkg::POS_W-1:0] w_run;

    assign w_out_load = (r_prem != '0) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_prem == '0) ||
                        ((r_prem == vtsi_pkg::CNT_W'(1)) && w_out_load);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_first    = (r_pos == vtsi_pkg::POS_FIRST);
    assign w_final    = r_plast && (r_prem == vtsi_pkg::CNT_W'(1));
    assign w_run      = r_pos - (vtsi_pkg::POS_SA_END - 5'd1);

    always_comb begin
        n_mode  = w_first ? i_cmd : r_mode;
        n_tci   = w_first ? {i_tag_pcp, 1'b0, i_tag_vid} : r_tci;
        n_seen  = w_first ? 1'b0 : r_seen;
        n_found = w_first ? 1'b0 : r_found;
        n_vid   = w_first ? '0 : r_vid;
        n_inner = w_first ? '0 : r_inner;
        n_held  = r_held;
        for (int i = 0; i < vtsi_pkg::MAX_RESULTS; i++) begin
            n_pb[i] = i_data_byte;
        end
        n_cnt = '0;

        if (n_mode == vtsi_pkg::CMD_INSERT) begin
            n_pb[0] = i_data_byte;
            n_cnt   = vtsi_pkg::CNT_W'(1);
            if (r_pos == vtsi_pkg::POS_SA_END) begin
                n_pb[1] = vtsi_pkg::TPID_HI;
                n_pb[2] = vtsi_pkg::TPID_LO;
                n_pb[3] = n_tci[15:8];
                n_pb[4] = n_tci[7:0];
                n_cnt   = vtsi_pkg::CNT_W'(vtsi_pkg::MAX_RESULTS);
            end
        end else if (r_pos >= vtsi_pkg::POS_SA_END && r_pos <= vtsi_pkg::POS_TYPE_LO) begin
            if (r_pos == vtsi_pkg::POS_SA_END) begin
                n_held[0] = i_data_byte;
            end else if (r_pos == vtsi_pkg::POS_TYPE_HI) begin
                n_held[1] = i_data_byte;
            end else begin
                n_held[2] = i_data_byte;
                n_seen    = (r_held[1] == vtsi_pkg::TPID_HI) &&
                            (i_data_byte == vtsi_pkg::TPID_LO);
            end
            n_pb[0] = n_held[0];
            n_pb[1] = n_held[1];
            n_pb[2] = n_held[2];
            if (i_last_byte) begin
                n_cnt = w_run[vtsi_pkg::CNT_W-1:0];
            end else if (r_pos == vtsi_pkg::POS_TYPE_LO && !n_seen) begin
                n_cnt = vtsi_pkg::CNT_W'(3);
            end
        end else if ((r_pos == vtsi_pkg::POS_TCI_HI || r_pos == vtsi_pkg::POS_TCI_LO)
                     && r_seen) begin
            if (r_pos == vtsi_pkg::POS_TCI_HI) begin
                n_held[3] = i_data_byte;
                if (i_last_byte) begin
                    n_pb[0] = r_held[0];
                    n_pb[1] = r_held[1];
                    n_pb[2] = r_held[2];
                    n_pb[3] = i_data_byte;
                    n_cnt   = vtsi_pkg::CNT_W'(4);
                end
            end else begin
                n_found = 1'b1;
                n_vid   = {r_held[3][3:0], i_data_byte};
                n_pb[0] = r_held[0];
                n_cnt   = vtsi_pkg::CNT_W'(1);
            end
        end else begin
            if (n_found && r_pos == vtsi_pkg::POS_INNER_HI) begin
                n_held[0] = i_data_byte;
            end else if (n_found && r_pos == vtsi_pkg::POS_INNER_LO) begin
                n_inner = {r_held[0], i_data_byte};
            end
            n_pb[0] = i_data_byte;
            n_cnt   = vtsi_pkg::CNT_W'(1);
        end

        if (i_last_byte) begin
            n_pos = vtsi_pkg::POS_FIRST;
        end else if (r_pos < vtsi_pkg::POS_MAX) begin
            n_pos = r_pos + 5'd1;
        end else begin
            n_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= vtsi_pkg::POS_FIRST;
            r_mode      <= vtsi_pkg::CMD_STRIP;
            r_tci       <= '0;
            r_seen      <= 1'b0;
            r_found     <= 1'b0;
            r_vid       <= '0;
            r_inner     <= '0;
            r_prem      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_pos   <= n_pos;
                r_mode  <= n_mode;
                r_tci   <= n_tci;
                r_seen  <= n_seen;
                r_found <= n_found;
                r_vid   <= n_vid;
                r_inner <= n_inner;
                r_prem  <= n_cnt;
            end else if (w_out_load) begin
                r_prem  <= r_prem - vtsi_pkg::CNT_W'(1);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_held   <= n_held;
            r_pb     <= n_pb;
            r_plast  <= i_last_byte;
            r_pfound <= n_found;
            r_pvid   <= n_vid;
            r_pinner <= n_inner;
        end else if (w_out_load) begin
            for (int i = 0; i < vtsi_pkg::MAX_RESULTS - 1; i++) begin
                r_pb[i] <= r_pb[i+1];
            end
        end
        if (w_out_load) begin
            r_out_byte    <= r_pb[0];
            r_out_last    <= w_final;
            r_out_removed <= w_final && r_pfound;
            r_out_vid     <= (w_final && r_pfound) ? r_pvid : '0;
            r_out_inner   <= (w_final && r_pfound) ? r_pinner : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_byte        = r_out_byte;
    assign o_out_last        = r_out_last;
    assign o_tag_removed     = r_out_removed;
    assign o_removed_vid     = r_out_vid;
    assign o_inner_ethertype = r_out_inner;

`ifndef SYNTHESIS
    a_prem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prem <= vtsi_pkg::CNT_W'(vtsi_pkg::MAX_RESULTS))
        else $error("pending count out of range");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prem != '0) && !r_out_valid |=> r_out_valid)
        else $error("pending word not moved to an empty output register");

    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_last |->
            !o_tag_removed && (o_removed_vid == '0) && (o_inner_ethertype == '0))
        else $error("strip status on a word that is not the last");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (n_cnt == '0) |=> (r_prem == '0))
        else $error("pending buffer not empty after a held byte");
`endif

endmodule

// ===== verif/tb_vlan_tag_strip_insert.sv =====
`timescale 1ns / 1ps

module tb_vlan_tag_strip_insert;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic        removed;
        logic [11:0] vid;
        logic [15:0] itype;
    } t_frame_word;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;
    typedef enum int {HDR_PLAIN, HDR_TPID, HDR_NEAR} t_hdr;

    class t_frame_board;
        t_frame_word rewritten_words[$];
        int          position;
        logic [7:0]  held[5];
        logic        mode;
        logic [15:0] tci;
        logic [15:0] seen_type;
        logic [11:0] found_vid;
        logic [15:0] found_inner;
        logic        tag_found;
        int          mismatches;
        int          checked;

        function void clear();
            position    = 0;
            mode        = vtsi_pkg::CMD_STRIP;
            tci         = '0;
            seen_type   = '0;
            found_vid   = '0;
            found_inner = '0;
            tag_found   = 1'b0;
            foreach (held[i]) held[i] = '0;
            rewritten_words.delete();
            mismatches  = 0;
            checked     = 0;
        endfunction

        function void push_word(logic [7:0] b, logic last);
            t_frame_word w;
            w.data    = b;
            w.last    = last;
            w.removed = 1'b0;
            w.vid     = '0;
            w.itype   = '0;
            if (last && tag_found) begin
                w.removed = 1'b1;
                w.vid     = found_vid;
                w.itype   = found_inner;
            end
            rewritten_words.push_back(w);
        endfunction

        function void release_held(int n, logic last);
            for (int i = 0; i < n && i < 5; i++)
                push_word(held[i], last && (i + 1 == n));
        endfunction

        function void note_byte(logic cmd, logic [7:0] b, logic last,
                                logic [11:0] vid, logic [2:0] pcp);
            int p;
            p = position;
            if (p == vtsi_pkg::POS_FIRST) begin
                mode        = cmd;
                tci         = {pcp, 1'b0, vid};
                seen_type   = '0;
                found_vid   = '0;
                found_inner = '0;
                tag_found   = 1'b0;
            end
            if (mode == vtsi_pkg::CMD_INSERT) begin
                push_word(b, last && p != vtsi_pkg::POS_SA_END);
                if (p == vtsi_pkg::POS_SA_END) begin
                    push_word(vtsi_pkg::TPID_HI, 1'b0);
                    push_word(vtsi_pkg::TPID_LO, 1'b0);
                    push_word(tci[15:8], 1'b0);
                    push_word(tci[7:0], last);
                end
            end else if (p >= vtsi_pkg::POS_SA_END && p <= vtsi_pkg::POS_TYPE_LO) begin
                held[p - vtsi_pkg::POS_SA_END] = b;
                if (p == vtsi_pkg::POS_TYPE_LO)
                    seen_type = {held[1], b};
                if (last)
                    release_held(p - 10, 1'b1);
                else if (p == vtsi_pkg::POS_TYPE_LO &&
                         seen_type != {vtsi_pkg::TPID_HI, vtsi_pkg::TPID_LO})
                    release_held(3, 1'b0);
            end else if ((p == vtsi_pkg::POS_TCI_HI || p == vtsi_pkg::POS_TCI_LO) &&
                         seen_type == {vtsi_pkg::TPID_HI, vtsi_pkg::TPID_LO}) begin
                held[p - vtsi_pkg::POS_SA_END] = b;
                if (p == vtsi_pkg::POS_TCI_LO) begin
                    tag_found = 1'b1;
                    found_vid = {held[3][3:0], b};
                    push_word(held[0], last);
                end else if (last) begin
                    release_held(4, 1'b1);
                end
            end else begin
                if (tag_found && p == vtsi_pkg::POS_INNER_HI)
                    held[0] = b;
                else if (tag_found && p == vtsi_pkg::POS_INNER_LO)
                    found_inner = {held[0], b};
                push_word(b, last);
            end
            if (last)
                position = 0;
            else if (p < vtsi_pkg::POS_MAX)
                position = p + 1;
        endfunction

        function void check_word(logic [7:0] b, logic last, logic removed,
                                 logic [11:0] vid, logic [15:0] itype);
            t_frame_word w;
            checked++;
            if (rewritten_words.size() == 0) begin
                $error("output word %0h with nothing expected", b);
                mismatches++;
                return;
            end
            w = rewritten_words.pop_front();
            if (b !== w.data) begin
                $error("out_byte expected %0h actual %0h", w.data, b);
                mismatches++;
            end
            if (last !== w.last) begin
                $error("out_last expected %0h actual %0h", w.last, last);
                mismatches++;
            end
            if (removed !== w.removed) begin
                $error("tag_removed expected %0h actual %0h", w.removed, removed);
                mismatches++;
            end
            if (vid !== w.vid) begin
                $error("removed_vid expected %0h actual %0h", w.vid, vid);
                mismatches++;
            end
            if (itype !== w.itype) begin
                $error("inner_ethertype expected %0h actual %0h", w.itype, itype);
                mismatches++;
            end
        endfunction

        function int pending();
            return rewritten_words.size();
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_OFF_LEN   = 120;
    localparam int HOLD_AFTER     = 30;
    localparam int IDLE_PCT       = 22;
    localparam int ITEM_TARGET    = 105;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_cmd = vtsi_pkg::CMD_STRIP;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic [11:0] i_tag_vid = '0;
    logic [2:0]  i_tag_pcp = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic        o_tag_removed;
    logic [11:0] o_removed_vid;
    logic [15:0] o_inner_ethertype;

    t_frame_board board = new;
    bit calm = 1'b0;
    int frames_sent = 0;
    int bytes_sent = 0;

    vlan_tag_strip_insert dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .i_tag_vid         (i_tag_vid),
        .i_tag_pcp         (i_tag_pcp),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_byte        (o_out_byte),
        .o_out_last        (o_out_last),
        .o_tag_removed     (o_tag_removed),
        .o_removed_vid     (o_removed_vid),
        .o_inner_ethertype (o_inner_ethertype)
    );

    always #4 i_clk = ~i_clk;

    task automatic send_byte(logic cmd, logic [7:0] b, logic last,
                             logic [11:0] vid, logic [2:0] pcp);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_data_byte <= b;
        i_last_byte <= last;
        i_tag_vid   <= vid;
        i_tag_pcp   <= pcp;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        board.note_byte(cmd, b, last, vid, pcp);
        bytes_sent++;
    endtask

    task automatic send_frame(logic cmd, int len, t_hdr hdr, logic [11:0] vid,
                              logic [2:0] pcp, t_fill fill);
        logic [7:0]  b;
        logic [15:0] near_type;
        near_type = {vtsi_pkg::TPID_HI, vtsi_pkg::TPID_LO} ^ (16'h1 << $urandom_range(15));
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom_range(255));
            endcase
            if (hdr == HDR_TPID && i == vtsi_pkg::POS_TYPE_HI) b = vtsi_pkg::TPID_HI;
            if (hdr == HDR_TPID && i == vtsi_pkg::POS_TYPE_LO) b = vtsi_pkg::TPID_LO;
            if (hdr == HDR_NEAR && i == vtsi_pkg::POS_TYPE_HI) b = near_type[15:8];
            if (hdr == HDR_NEAR && i == vtsi_pkg::POS_TYPE_LO) b = near_type[7:0];
            if (i == 0)
                send_byte(cmd, b, len == 1, vid, pcp);
            else
                send_byte(1'($urandom_range(1)), b, i == len - 1,
                          12'($urandom_range(4095)), 3'($urandom_range(7)));
        end
        frames_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // receiver: random back-pressure plus one long hold-off
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (o_out_valid && i_out_ready)
                board.check_word(o_out_byte, o_out_last, o_tag_removed,
                                 o_removed_vid, o_inner_ethertype);
            @(posedge i_clk);
            if (!hold_done && board.checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge i_clk);
            end
            i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(negedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", quiet);
                $display("vlan_tag_strip_insert test failed");
                $finish;
            end
        end
    end

    initial begin
        int    len;
        int    pick;
        logic  cmd;
        t_hdr  hdr;
        board.clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames
        send_frame(vtsi_pkg::CMD_STRIP, 16, HDR_TPID, 12'h000, 3'd0, FILL_RANDOM);
        send_frame(vtsi_pkg::CMD_STRIP, 15, HDR_TPID, 12'h000, 3'd0, FILL_RANDOM);
        send_frame(vtsi_pkg::CMD_STRIP, 14, HDR_NEAR, 12'h000, 3'd0, FILL_RANDOM);
        send_frame(vtsi_pkg::CMD_STRIP, 1, HDR_PLAIN, 12'h000, 3'd0, FILL_ZERO);
        send_frame(vtsi_pkg::CMD_INSERT, 12, HDR_PLAIN, 12'hFFF, 3'd7, FILL_ONES);
        send_frame(vtsi_pkg::CMD_INSERT, 11, HDR_PLAIN, 12'hABC, 3'd5, FILL_RANDOM);

        // sender pause until every word is out
        wait_drained();

        // long frame with no idling on either side
        calm = 1'b1;
        send_frame(vtsi_pkg::CMD_STRIP, 33, HDR_TPID, 12'h5A5, 3'd2, FILL_ONES);
        calm = 1'b0;

        while (bytes_sent < ITEM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 20)      len = $urandom_range(1, 13);
            else if (pick < 55) len = $urandom_range(14, 18);
            else                len = $urandom_range(19, 24);
            cmd  = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 75)      hdr = HDR_TPID;
            else if (pick < 88) hdr = HDR_NEAR;
            else                hdr = HDR_PLAIN;
            send_frame(cmd, len, hdr, 12'($urandom_range(4095)), 3'($urandom_range(7)),
                       FILL_RANDOM);
        end

        wait_drained();
        if (board.pending() != 0) begin
            $error("%0d output words never arrived", board.pending());
            board.mismatches++;
        end

        $display("ran %0d frames (%0d bytes) through strip and insert, %0d words checked",
                 frames_sent, bytes_sent, board.checked);
        $display("short, near-miss, tagged and saturating frames, plus a long output stall");
        if (board.mismatches == 0)
            $display("vlan_tag_strip_insert test passed");
        else
            $display("vlan_tag_strip_insert test failed");
        $finish;
    end

endmodule
